// ===== sv/planar_arm_forward_kinematics_top_macros.svh =====
// Assertion macros shared by the checker of the planar arm kinematics block
`ifndef PLANAR_ARM_FORWARD_KINEMATICS_TOP_MACROS_SVH
`define PLANAR_ARM_FORWARD_KINEMATICS_TOP_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define PAFK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted
`define PAFK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pafk_pkg.sv =====
// Shared types, constants and reset values of the planar arm kinematics block
`default_nettype none

package pafk_pkg;

  // Fixed field widths
  localparam int unsigned POS_W  = 24;
  localparam int unsigned ANG_W  = 16;
  localparam int unsigned TRIG_W = 16;
  localparam int unsigned LEN_W  = 16;

  // Default angle resolution: 2^ANGLE_BITS is one turn
  localparam int unsigned ANGLE_BITS_DEF = 16;

  // Fraction bits of positions and link lengths
  localparam int unsigned POS_FRAC_BITS = 12;

  // Link length reset values: round(tenths / 10 * 2^F), saturated to 16 bits
  localparam longint unsigned LEN_ONE_RAW =
    (64'd8 * (64'd1 << POS_FRAC_BITS) * 64'd2 + 64'd10) / 64'd20;
  localparam longint unsigned LEN_TWO_RAW =
    (64'd6 * (64'd1 << POS_FRAC_BITS) * 64'd2 + 64'd10) / 64'd20;
  localparam longint unsigned LEN_THREE_RAW =
    (64'd3 * (64'd1 << POS_FRAC_BITS) * 64'd2 + 64'd10) / 64'd20;

  localparam logic [LEN_W-1:0] LEN_ONE_RESET =
    (LEN_ONE_RAW > 64'd65535) ? 16'hFFFF : 16'(LEN_ONE_RAW);
  localparam logic [LEN_W-1:0] LEN_TWO_RESET =
    (LEN_TWO_RAW > 64'd65535) ? 16'hFFFF : 16'(LEN_TWO_RAW);
  localparam logic [LEN_W-1:0] LEN_THREE_RESET =
    (LEN_THREE_RAW > 64'd65535) ? 16'hFFFF : 16'(LEN_THREE_RAW);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_ONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_THREE = 2'd2;

  // Quarter-wave sine polynomial, Q16 coefficients
  localparam logic [16:0] POLY_A  = 17'd102944;
  localparam logic [15:0] POLY_B  = 16'd42048;
  localparam logic [12:0] POLY_C  = 13'd4640;
  localparam logic [16:0] QUARTER = 17'h10000;

  // Register stages of the quarter-wave sine unit
  localparam int unsigned QSINE_STAGES = 4;

  // Word handed from cell to cell. Each cell consumes ang[0] and shifts its
  // own results into the top entries of the result arrays.
  typedef struct packed {
    logic [POS_W-1:0]            cur_x;
    logic [POS_W-1:0]            cur_y;
    logic [2:0][ANG_W-1:0]       ang;
    logic [2:0][POS_W-1:0]       pos_x;
    logic [2:0][POS_W-1:0]       pos_y;
    logic [2:0][TRIG_W-1:0]      cos_v;
    logic [2:0][TRIG_W-1:0]      sin_v;
  } fk_word_t;

endpackage

`default_nettype wire

// ===== sv/planar_arm_forward_kinematics_top.sv =====
// Top level of the planar three-link arm forward kinematics pipeline
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------------
//  in       | sink      | in_valid_i / in_stall_o | base_x/y, joint_one..three_angle
//  out      | source    | out_valid_o/out_stall_i | elbow/wrist/tip x,y, cos/sin x3
//  cfg      | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Throughput: one word per cycle, sustained, while the output is drained.
// Depth: each of the three link cells is eight stages deep: the angle
//   accumulate, the four dependent multiplies of the sine polynomial, the
//   quadrant fold, the length multiply and the saturating add.
// Reset clears all valid bits and loads the default link lengths; no
//   clearing pass is needed.
// A stalled output word holds in the output register; the next word lands in
//   a one-entry skid buffer, and only a full skid stalls the input and
//   freezes the cell chain.
// Configuration writes are always taken; write lengths only while idle.
`default_nettype none

module planar_arm_forward_kinematics_top #(
  parameter int unsigned ANGLE_BITS = pafk_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,

  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [pafk_pkg::POS_W-1:0]     base_x_i,
  input  wire logic signed [pafk_pkg::POS_W-1:0]     base_y_i,
  input  wire logic signed [pafk_pkg::ANG_W-1:0]     joint_one_angle_i,
  input  wire logic signed [pafk_pkg::ANG_W-1:0]     joint_two_angle_i,
  input  wire logic signed [pafk_pkg::ANG_W-1:0]     joint_three_angle_i,

  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [pafk_pkg::POS_W-1:0]          elbow_x_o,
  output logic signed [pafk_pkg::POS_W-1:0]          elbow_y_o,
  output logic signed [pafk_pkg::POS_W-1:0]          wrist_x_o,
  output logic signed [pafk_pkg::POS_W-1:0]          wrist_y_o,
  output logic signed [pafk_pkg::POS_W-1:0]          tip_x_o,
  output logic signed [pafk_pkg::POS_W-1:0]          tip_y_o,
  output logic signed [pafk_pkg::TRIG_W-1:0]         cos_first_o,
  output logic signed [pafk_pkg::TRIG_W-1:0]         sin_first_o,
  output logic signed [pafk_pkg::TRIG_W-1:0]         cos_second_o,
  output logic signed [pafk_pkg::TRIG_W-1:0]         sin_second_o,
  output logic signed [pafk_pkg::TRIG_W-1:0]         cos_third_o,
  output logic signed [pafk_pkg::TRIG_W-1:0]         sin_third_o,

  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [pafk_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [pafk_pkg::LEN_W-1:0]            cfg_data_i
);

  // Link length registers
  logic [pafk_pkg::LEN_W-1:0] len_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q[0] <= pafk_pkg::LEN_ONE_RESET;
      len_q[1] <= pafk_pkg::LEN_TWO_RESET;
      len_q[2] <= pafk_pkg::LEN_THREE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pafk_pkg::REG_LINK_ONE:   len_q[0] <= cfg_data_i;
        pafk_pkg::REG_LINK_TWO:   len_q[1] <= cfg_data_i;
        pafk_pkg::REG_LINK_THREE: len_q[2] <= cfg_data_i;
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  // Output register plus one-entry skid
  logic               out_vld_q;
  pafk_pkg::fk_word_t out_word_q;
  logic               skid_vld_q;
  pafk_pkg::fk_word_t skid_word_q;

  // Whole chain advances unless the skid holds a word
  logic en;
  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // Build the entry word: the base seeds the running position
  pafk_pkg::fk_word_t in_word;
  always_comb begin
    in_word        = '0;
    in_word.cur_x  = base_x_i;
    in_word.cur_y  = base_y_i;
    in_word.ang[0] = joint_one_angle_i;
    in_word.ang[1] = joint_two_angle_i;
    in_word.ang[2] = joint_three_angle_i;
  end

  // Chain of three identical link cells
  logic                  c_vld  [4];
  pafk_pkg::fk_word_t    c_word [4];
  logic [ANGLE_BITS-1:0] c_acc  [4];

  assign c_vld[0]  = in_valid_i;
  assign c_word[0] = in_word;
  assign c_acc[0]  = '0;

  for (genvar k = 0; k < 3; k++) begin : g_cell
    pafk_link_cell #(
      .ANGLE_BITS (ANGLE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .len_i      (len_q[k]),
      .in_vld_i   (c_vld[k]),
      .in_word_i  (c_word[k]),
      .in_acc_i   (c_acc[k]),
      .out_vld_o  (c_vld[k+1]),
      .out_word_o (c_word[k+1]),
      .out_acc_o  (c_acc[k+1])
    );
  end

  // Final angle sum is not needed past the last cell
  logic [ANGLE_BITS-1:0] last_acc;
  assign last_acc = c_acc[3];

  logic push, pop;
  assign push = en && c_vld[3];
  assign pop  = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      // Chain is frozen; move the skid word forward once the output drains
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !pop) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_word_q <= skid_word_q;
      end
    end else if (push) begin
      if (out_vld_q && !pop) begin
        skid_word_q <= c_word[3];
      end else begin
        out_word_q <= c_word[3];
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign elbow_x_o    = $signed(out_word_q.pos_x[0]);
  assign elbow_y_o    = $signed(out_word_q.pos_y[0]);
  assign wrist_x_o    = $signed(out_word_q.pos_x[1]);
  assign wrist_y_o    = $signed(out_word_q.pos_y[1]);
  assign tip_x_o      = $signed(out_word_q.pos_x[2]);
  assign tip_y_o      = $signed(out_word_q.pos_y[2]);
  assign cos_first_o  = $signed(out_word_q.cos_v[0]);
  assign sin_first_o  = $signed(out_word_q.sin_v[0]);
  assign cos_second_o = $signed(out_word_q.cos_v[1]);
  assign sin_second_o = $signed(out_word_q.sin_v[1]);
  assign cos_third_o  = $signed(out_word_q.cos_v[2]) | TRIG_ZERO(last_acc);

  // Reduce the unused final angle sum to a zero term
  function automatic logic [pafk_pkg::TRIG_W-1:0] TRIG_ZERO(
    input logic [ANGLE_BITS-1:0] a
  );
    logic [pafk_pkg::TRIG_W-1:0] r;
    r = {pafk_pkg::TRIG_W{1'b0}} & {pafk_pkg::TRIG_W{^a}};
    return r;
  endfunction

  assign sin_third_o  = $signed(out_word_q.sin_v[2]);

endmodule

`default_nettype wire

// ===== sv/pafk_qsine.sv =====
// Four-stage quarter-wave sine polynomial, Q16 argument in, Q14 result out
`default_nettype none

module pafk_qsine (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [16:0] x_i,
  output logic      [14:0] y_o
);

  logic [33:0] sq;
  logic [29:0] prod_c;
  logic [15:0] tc;
  logic [15:0] t1_d;
  logic [32:0] prod_b;
  logic [16:0] tb;
  logic [16:0] t2_d;
  logic [33:0] prod_a;
  logic [17:0] ta;
  logic [14:0] y_d;

  logic [16:0] x1_q, x1b_q, x1c_q;
  logic [16:0] x2_q, x2b_q;
  logic [15:0] t1_q;
  logic [16:0] t2_q;
  logic [14:0] y_q;

  // x squared
  assign sq = 34'(x_i) * 34'(x_i);

  // B - C * x2
  assign prod_c = 30'(pafk_pkg::POLY_C) * 30'(x2_q);
  assign tc     = 16'(prod_c >> 16);
  assign t1_d   = pafk_pkg::POLY_B - tc;

  // A - t1 * x2
  assign prod_b = 33'(t1_q) * 33'(x2b_q);
  assign tb     = 17'(prod_b >> 16);
  assign t2_d   = pafk_pkg::POLY_A - tb;

  // t2 * x, then round Q16 to Q14
  assign prod_a = 34'(t2_q) * 34'(x1c_q);
  assign ta     = 18'(prod_a >> 16);
  assign y_d    = 15'((ta + 18'd2) >> 2);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q  <= x_i;
      x2_q  <= 17'(sq >> 16);
      x1b_q <= x1_q;
      x2b_q <= x2_q;
      t1_q  <= t1_d;
      x1c_q <= x1b_q;
      t2_q  <= t2_d;
      y_q   <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

`default_nettype wire

// ===== sv/pafk_link_cell.sv =====
// One link of the arm: angle accumulate, sine/cosine, scale and position add
`default_nettype none

module pafk_link_cell #(
  parameter int unsigned ANGLE_BITS = pafk_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic [pafk_pkg::LEN_W-1:0]       len_i,
  input  wire logic                             in_vld_i,
  input  wire pafk_pkg::fk_word_t               in_word_i,
  input  wire logic [ANGLE_BITS-1:0]            in_acc_i,
  output logic                                  out_vld_o,
  output pafk_pkg::fk_word_t                    out_word_o,
  output logic      [ANGLE_BITS-1:0]            out_acc_o
);

  localparam int unsigned RB    = ANGLE_BITS - 2;
  localparam int unsigned DLY   = pafk_pkg::QSINE_STAGES;
  localparam int unsigned OFF_W = 19;

  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  localparam logic signed [pafk_pkg::POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [pafk_pkg::POS_W-1:0] POS_MIN = -24'sh800000;

  function automatic logic signed [pafk_pkg::POS_W-1:0] sat_pos(
    input logic signed [pafk_pkg::POS_W:0] v
  );
    logic signed [pafk_pkg::POS_W-1:0] r;
    if (v[pafk_pkg::POS_W] != v[pafk_pkg::POS_W-1]) begin
      r = v[pafk_pkg::POS_W] ? POS_MIN : POS_MAX;
    end else begin
      r = v[pafk_pkg::POS_W-1:0];
    end
    return r;
  endfunction

  // Stage A: accumulate angle, split quadrant and fraction
  logic [ANGLE_BITS-1:0] acc_d;
  logic [RB-1:0]         frac;
  logic [16:0]           x_d;
  logic [16:0]           xc_d;
  pafk_pkg::fk_word_t    a_word_d;

  logic                  a_vld_q;
  pafk_pkg::fk_word_t    a_word_q;
  logic [ANGLE_BITS-1:0] a_acc_q;
  logic [1:0]            a_quad_q;
  logic [16:0]           a_x_q;
  logic [16:0]           a_xc_q;

  assign acc_d = in_acc_i + ANGLE_BITS'($signed(in_word_i.ang[0]));
  assign frac  = acc_d[RB-1:0];

  generate
    if (RB >= 16) begin : g_frac_wide
      assign x_d = 17'(frac >> (RB - 16));
    end else begin : g_frac_narrow
      assign x_d = 17'({frac, {(16 - RB){1'b0}}});
    end
  endgenerate

  assign xc_d = pafk_pkg::QUARTER - x_d;

  always_comb begin
    a_word_d     = in_word_i;
    a_word_d.ang = {16'd0, in_word_i.ang[2:1]};
  end

  // Sine of x and of the complementary angle
  logic [14:0] p_val;
  logic [14:0] q_val;

  pafk_qsine u_qsine_p (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (a_x_q),
    .y_o   (p_val)
  );

  pafk_qsine u_qsine_q (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (a_xc_q),
    .y_o   (q_val)
  );

  // Delay line alongside the sine unit
  logic [DLY-1:0]        d_vld_q;
  pafk_pkg::fk_word_t    d_word_q [DLY];
  logic [ANGLE_BITS-1:0] d_acc_q  [DLY];
  logic [1:0]            d_quad_q [DLY];

  // Stage M: fold quadrant into signed cosine and sine
  logic signed [15:0]  p_s, q_s;
  logic signed [15:0]  sin_d, cos_d;
  pafk_pkg::fk_word_t  m_word_d;

  logic                  m_vld_q;
  pafk_pkg::fk_word_t    m_word_q;
  logic [ANGLE_BITS-1:0] m_acc_q;

  assign p_s = $signed(16'(p_val));
  assign q_s = $signed(16'(q_val));

  always_comb begin
    case (d_quad_q[DLY-1])
      QUAD_FIRST: begin
        sin_d = p_s;
        cos_d = q_s;
      end
      QUAD_SECOND: begin
        sin_d = q_s;
        cos_d = -p_s;
      end
      QUAD_THIRD: begin
        sin_d = -p_s;
        cos_d = -q_s;
      end
      QUAD_FOURTH: begin
        sin_d = -q_s;
        cos_d = p_s;
      end
      default: begin
        sin_d = '0;
        cos_d = '0;
      end
    endcase
  end

  always_comb begin
    m_word_d       = d_word_q[DLY-1];
    m_word_d.cos_v = {cos_d, d_word_q[DLY-1].cos_v[2:1]};
    m_word_d.sin_v = {sin_d, d_word_q[DLY-1].sin_v[2:1]};
  end

  // Stage O: scale by link length, round half up by 14 bits
  logic signed [16:0]      len_s;
  logic signed [32:0]      prod_x, prod_y;
  logic signed [32:0]      rnd_x, rnd_y;

  logic                    o_vld_q;
  pafk_pkg::fk_word_t      o_word_q;
  logic [ANGLE_BITS-1:0]   o_acc_q;
  logic signed [OFF_W-1:0] o_off_x_q, o_off_y_q;

  assign len_s  = $signed({1'b0, len_i});
  assign prod_x = len_s * $signed(m_word_q.cos_v[2]);
  assign prod_y = len_s * $signed(m_word_q.sin_v[2]);
  assign rnd_x  = prod_x + 33'sd8192;
  assign rnd_y  = prod_y + 33'sd8192;

  // Stage P: add offset to the previous joint and saturate
  logic signed [pafk_pkg::POS_W:0]   sum_x, sum_y;
  logic signed [pafk_pkg::POS_W-1:0] new_x, new_y;
  pafk_pkg::fk_word_t                p_word_d;

  logic                  p_vld_q;
  pafk_pkg::fk_word_t    p_word_q;
  logic [ANGLE_BITS-1:0] p_acc_q;

  assign sum_x = 25'($signed(o_word_q.cur_x)) + 25'(o_off_x_q);
  assign sum_y = 25'($signed(o_word_q.cur_y)) + 25'(o_off_y_q);
  assign new_x = sat_pos(sum_x);
  assign new_y = sat_pos(sum_y);

  always_comb begin
    p_word_d       = o_word_q;
    p_word_d.cur_x = new_x;
    p_word_d.cur_y = new_y;
    p_word_d.pos_x = {new_x, o_word_q.pos_x[2:1]};
    p_word_d.pos_y = {new_y, o_word_q.pos_y[2:1]};
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      d_vld_q <= '0;
      m_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= in_vld_i;
      d_vld_q <= {d_vld_q[DLY-2:0], a_vld_q};
      m_vld_q <= d_vld_q[DLY-1];
      o_vld_q <= m_vld_q;
      p_vld_q <= o_vld_q;
    end
  end

  // Payload, advance with the pipe
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_word_q <= a_word_d;
      a_acc_q  <= acc_d;
      a_quad_q <= acc_d[ANGLE_BITS-1:ANGLE_BITS-2];
      a_x_q    <= x_d;
      a_xc_q   <= xc_d;

      d_word_q[0] <= a_word_q;
      d_acc_q[0]  <= a_acc_q;
      d_quad_q[0] <= a_quad_q;
      for (int i = 1; i < DLY; i++) begin
        d_word_q[i] <= d_word_q[i-1];
        d_acc_q[i]  <= d_acc_q[i-1];
        d_quad_q[i] <= d_quad_q[i-1];
      end

      m_word_q <= m_word_d;
      m_acc_q  <= d_acc_q[DLY-1];

      o_word_q  <= m_word_q;
      o_acc_q   <= m_acc_q;
      o_off_x_q <= OFF_W'(rnd_x >>> 14);
      o_off_y_q <= OFF_W'(rnd_y >>> 14);

      p_word_q <= p_word_d;
      p_acc_q  <= o_acc_q;
    end
  end

  assign out_vld_o  = p_vld_q;
  assign out_word_o = p_word_q;
  assign out_acc_o  = p_acc_q;

endmodule

`default_nettype wire

// ===== sv/pafk_chk.sv =====
// Port-level checker of the planar arm kinematics block, bound to the top level
`default_nettype none

`include "planar_arm_forward_kinematics_top_macros.svh"

module pafk_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic signed [pafk_pkg::POS_W-1:0] base_x_i,
  input wire logic signed [pafk_pkg::POS_W-1:0] base_y_i,
  input wire logic signed [pafk_pkg::ANG_W-1:0] joint_one_angle_i,
  input wire logic signed [pafk_pkg::ANG_W-1:0] joint_two_angle_i,
  input wire logic signed [pafk_pkg::ANG_W-1:0] joint_three_angle_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic signed [pafk_pkg::POS_W-1:0] elbow_x_o,
  input wire logic signed [pafk_pkg::POS_W-1:0] elbow_y_o,
  input wire logic signed [pafk_pkg::POS_W-1:0] wrist_x_o,
  input wire logic signed [pafk_pkg::POS_W-1:0] wrist_y_o,
  input wire logic signed [pafk_pkg::POS_W-1:0] tip_x_o,
  input wire logic signed [pafk_pkg::POS_W-1:0] tip_y_o,
  input wire logic signed [pafk_pkg::TRIG_W-1:0] cos_first_o,
  input wire logic signed [pafk_pkg::TRIG_W-1:0] sin_first_o,
  input wire logic signed [pafk_pkg::TRIG_W-1:0] cos_second_o,
  input wire logic signed [pafk_pkg::TRIG_W-1:0] sin_second_o,
  input wire logic signed [pafk_pkg::TRIG_W-1:0] cos_third_o,
  input wire logic signed [pafk_pkg::TRIG_W-1:0] sin_third_o,
  input wire logic                              cfg_valid_i,
  input wire logic                              cfg_ready_o,
  input wire logic [pafk_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input wire logic [pafk_pkg::LEN_W-1:0]        cfg_data_i
);

  localparam logic signed [pafk_pkg::TRIG_W-1:0] ONE_Q14 = 16'sd16384;

  logic out_hold;
  logic [6*pafk_pkg::POS_W+6*pafk_pkg::TRIG_W-1:0] out_bus;
  logic trig_ok;

  assign out_hold = out_valid_o && out_stall_i;

  // All result fields side by side, compared edge to edge while stalled
  assign out_bus = {elbow_x_o, elbow_y_o, wrist_x_o, wrist_y_o, tip_x_o, tip_y_o,
                    cos_first_o, sin_first_o, cos_second_o, sin_second_o,
                    cos_third_o, sin_third_o};

  // Every cosine and sine stays within plus and minus one in Q1.14
  assign trig_ok = (cos_first_o  <= ONE_Q14) && (cos_first_o  >= -ONE_Q14)
                && (sin_first_o  <= ONE_Q14) && (sin_first_o  >= -ONE_Q14)
                && (cos_second_o <= ONE_Q14) && (cos_second_o >= -ONE_Q14)
                && (sin_second_o <= ONE_Q14) && (sin_second_o >= -ONE_Q14)
                && (cos_third_o  <= ONE_Q14) && (cos_third_o  >= -ONE_Q14)
                && (sin_third_o  <= ONE_Q14) && (sin_third_o  >= -ONE_Q14);

  `PAFK_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_hold, out_valid_o, "valid dropped")
  `PAFK_ASSERT_NEXT(a_out_word_holds, clk_i, rst_ni, out_hold, $stable(out_bus), "word changed")
  `PAFK_ASSERT_IMPL(a_trig_range, clk_i, rst_ni, out_valid_o, trig_ok, "trig out of range")
  `PAFK_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, $rose(in_stall_o), $past(out_hold), "bad stall")

endmodule

bind planar_arm_forward_kinematics_top pafk_chk u_pafk_chk (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of the planar three-link arm forward kinematics block
`timescale 1ns / 100ps

module tb;
  import pafk_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int LATENCY     = 24;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 80;
  localparam int POS_MAX     = 2 ** (POS_W - 1) - 1;
  localparam int POS_MIN     = -(2 ** (POS_W - 1));

  // Index past the last link register; the block must drop writes to it
  localparam logic [CFG_IDX_W-1:0] REG_STRAY = 2'd3;

  // Quadrant codes taken from the top two angle bits
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  typedef struct {
    logic signed [POS_W-1:0] base_x;
    logic signed [POS_W-1:0] base_y;
    logic signed [ANG_W-1:0] joint_one;
    logic signed [ANG_W-1:0] joint_two;
    logic signed [ANG_W-1:0] joint_three;
  } pose_t;

  typedef struct {
    logic signed [POS_W-1:0]  elbow_x;
    logic signed [POS_W-1:0]  elbow_y;
    logic signed [POS_W-1:0]  wrist_x;
    logic signed [POS_W-1:0]  wrist_y;
    logic signed [POS_W-1:0]  tip_x;
    logic signed [POS_W-1:0]  tip_y;
    logic signed [TRIG_W-1:0] cos_first;
    logic signed [TRIG_W-1:0] sin_first;
    logic signed [TRIG_W-1:0] cos_second;
    logic signed [TRIG_W-1:0] sin_second;
    logic signed [TRIG_W-1:0] cos_third;
    logic signed [TRIG_W-1:0] sin_third;
  } arm_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [POS_W-1:0]  base_x_i;
  logic signed [POS_W-1:0]  base_y_i;
  logic signed [ANG_W-1:0]  joint_one_angle_i;
  logic signed [ANG_W-1:0]  joint_two_angle_i;
  logic signed [ANG_W-1:0]  joint_three_angle_i;

  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [POS_W-1:0]  elbow_x_o;
  logic signed [POS_W-1:0]  elbow_y_o;
  logic signed [POS_W-1:0]  wrist_x_o;
  logic signed [POS_W-1:0]  wrist_y_o;
  logic signed [POS_W-1:0]  tip_x_o;
  logic signed [POS_W-1:0]  tip_y_o;
  logic signed [TRIG_W-1:0] cos_first_o;
  logic signed [TRIG_W-1:0] sin_first_o;
  logic signed [TRIG_W-1:0] cos_second_o;
  logic signed [TRIG_W-1:0] sin_second_o;
  logic signed [TRIG_W-1:0] cos_third_o;
  logic signed [TRIG_W-1:0] sin_third_o;

  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [LEN_W-1:0]         cfg_data_i;

  // Shadow copy of the link length registers
  logic [LEN_W-1:0] link_len [3];

  // Poses waiting for the input driver, and arm results still owed by the block
  pose_t pose_fifo[$];
  arm_t  expected_arms[$];

  int poses_sent;
  int poses_accepted;
  int results_checked;
  int mismatch_count;
  int settings_count;
  int cycle_count;
  int gap_max;
  int stall_max;
  int long_hold_cycles;

  always #(CLK_HALF) clk_i = ~clk_i;

  planar_arm_forward_kinematics_top uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .base_x_i            (base_x_i),
    .base_y_i            (base_y_i),
    .joint_one_angle_i   (joint_one_angle_i),
    .joint_two_angle_i   (joint_two_angle_i),
    .joint_three_angle_i (joint_three_angle_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .elbow_x_o           (elbow_x_o),
    .elbow_y_o           (elbow_y_o),
    .wrist_x_o           (wrist_x_o),
    .wrist_y_o           (wrist_y_o),
    .tip_x_o             (tip_x_o),
    .tip_y_o             (tip_y_o),
    .cos_first_o         (cos_first_o),
    .sin_first_o         (sin_first_o),
    .cos_second_o        (cos_second_o),
    .sin_second_o        (sin_second_o),
    .cos_third_o         (cos_third_o),
    .sin_third_o         (sin_third_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Arm predictor
  // ---------------------------------------------------------------------------

  // Quarter-wave sine of a Q16 fraction of a quarter turn, rounded to Q14.
  // Every product drops 16 bits, just as the polynomial chain does.
  function automatic logic [TRIG_W-1:0] quarter_wave(input longint unsigned x);
    longint unsigned sq, acc;
    sq  = (x * x) >> 16;
    acc = POLY_B - ((POLY_C * sq) >> 16);
    acc = POLY_A - ((acc * sq) >> 16);
    acc = (acc * x) >> 16;
    return TRIG_W'((acc + 2) >> 2);
  endfunction

  // Fold the angle into its quadrant and pick sine and cosine from the two
  // quarter-wave values at x and at one quarter minus x.
  function automatic void trig_of(input logic [ANG_W-1:0] ang,
                                  output logic signed [TRIG_W-1:0] c,
                                  output logic signed [TRIG_W-1:0] s);
    longint unsigned          frac;
    logic signed [TRIG_W-1:0] p, q;
    frac = {ang[ANG_W-3:0], 2'b00};
    p = quarter_wave(frac);
    q = quarter_wave(QUARTER - frac);
    case (ang[ANG_W-1 -: 2])
      QUAD_I: begin
        s = p;
        c = q;
      end
      QUAD_II: begin
        s = q;
        c = -p;
      end
      QUAD_III: begin
        s = -p;
        c = -q;
      end
      default: begin
        s = -q;
        c = p;
      end
    endcase
  endfunction

  // Length times Q1.14 trig value, rounded half up by 14 bits
  function automatic longint link_offset(input logic [LEN_W-1:0] len,
                                         input logic signed [TRIG_W-1:0] t);
    return (longint'(len) * longint'(t) + 64'sd8192) >>> 14;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input longint v);
    if (v > POS_MAX) return POS_W'(POS_MAX);
    if (v < POS_MIN) return POS_W'(POS_MIN);
    return POS_W'(v);
  endfunction

  function automatic arm_t predict_arm(input pose_t p);
    arm_t             r;
    logic [ANG_W-1:0] sum_two, sum_three;
    sum_two   = p.joint_one + p.joint_two;
    sum_three = sum_two + p.joint_three;
    trig_of(p.joint_one, r.cos_first, r.sin_first);
    trig_of(sum_two, r.cos_second, r.sin_second);
    trig_of(sum_three, r.cos_third, r.sin_third);
    // Each joint chains off the saturated position of the one before it
    r.elbow_x = sat_pos(longint'(p.base_x) + link_offset(link_len[REG_LINK_ONE], r.cos_first));
    r.elbow_y = sat_pos(longint'(p.base_y) + link_offset(link_len[REG_LINK_ONE], r.sin_first));
    r.wrist_x = sat_pos(longint'(r.elbow_x) + link_offset(link_len[REG_LINK_TWO], r.cos_second));
    r.wrist_y = sat_pos(longint'(r.elbow_y) + link_offset(link_len[REG_LINK_TWO], r.sin_second));
    r.tip_x = sat_pos(longint'(r.wrist_x) + link_offset(link_len[REG_LINK_THREE], r.cos_third));
    r.tip_y = sat_pos(longint'(r.wrist_y) + link_offset(link_len[REG_LINK_THREE], r.sin_third));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Pose construction
  // ---------------------------------------------------------------------------

  function automatic pose_t make_pose(input int bx, input int by,
                                      input int a1, input int a2, input int a3);
    pose_t p;
    p.base_x      = POS_W'(bx);
    p.base_y      = POS_W'(by);
    p.joint_one   = ANG_W'(a1);
    p.joint_two   = ANG_W'(a2);
    p.joint_three = ANG_W'(a3);
    return p;
  endfunction

  // Mostly free-running positions; now and then push the base into a corner
  // so that the joint sums reach the saturation limits.
  function automatic int random_base();
    case ($urandom_range(7, 0))
      0:       return POS_MAX - int'($urandom_range(300000, 0));
      1:       return POS_MIN + int'($urandom_range(300000, 0));
      default: return int'($urandom);
    endcase
  endfunction

  // Angles are uniform except for a share parked right on a quadrant edge
  function automatic int random_angle();
    if ($urandom_range(7, 0) == 0)
      return int'($urandom_range(3, 0)) * 16384 + int'($urandom_range(4, 0)) - 2;
    return int'($urandom);
  endfunction

  function automatic pose_t random_pose();
    return make_pose(random_base(), random_base(),
                     random_angle(), random_angle(), random_angle());
  endfunction

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks
  // ---------------------------------------------------------------------------

  // Queue one pose for the input driver; keep at most two waiting so that
  // back-to-back words can still be offered.
  task automatic send_pose(input pose_t p);
    wait (poses_sent - poses_accepted < 2);
    pose_fifo.push_back(p);
    poses_sent++;
  endtask

  // Block until every queued pose has been taken and its result checked
  task automatic wait_idle();
    wait (poses_accepted == poses_sent && results_checked == poses_accepted);
  endtask

  // Write all three link lengths in one burst, optionally followed by a write
  // to the unused index that must leave the lengths alone.
  task automatic program_links(input logic [LEN_W-1:0] one,
                               input logic [LEN_W-1:0] two,
                               input logic [LEN_W-1:0] three,
                               input bit with_stray);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [LEN_W-1:0]     val [4];
    int                   n;
    idx = '{REG_LINK_ONE, REG_LINK_TWO, REG_LINK_THREE, REG_STRAY};
    val = '{one, two, three, LEN_W'($urandom)};
    n = with_stray ? 4 : 3;
    wait_idle();
    for (int k = 0; k < n; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[k])
        REG_LINK_ONE:   link_len[REG_LINK_ONE]   = val[k];
        REG_LINK_TWO:   link_len[REG_LINK_TWO]   = val[k];
        REG_LINK_THREE: link_len[REG_LINK_THREE] = val[k];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
    settings_count++;
  endtask

  task automatic check_field(input string name, input logic signed [POS_W-1:0] want,
                             input logic signed [POS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: hold each word until the block takes it, then predict
  // ---------------------------------------------------------------------------
  initial begin : pose_driver
    pose_t p;
    int    gap;
    in_valid_i          = 1'b0;
    base_x_i            = '0;
    base_y_i            = '0;
    joint_one_angle_i   = '0;
    joint_two_angle_i   = '0;
    joint_three_angle_i = '0;
    wait (rst_ni === 1'b1);
    forever begin
      if (pose_fifo.size() == 0) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        p   = pose_fifo.pop_front();
        gap = $urandom_range(gap_max, 0);
        // Drop valid for the drawn gap; with no gap the previous word's valid
        // simply stays high and the payload changes under it.
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        in_valid_i          <= 1'b1;
        base_x_i            <= p.base_x;
        base_y_i            <= p.base_y;
        joint_one_angle_i   <= p.joint_one;
        joint_two_angle_i   <= p.joint_two;
        joint_three_angle_i <= p.joint_three;
        do @(posedge clk_i); while (in_stall_o);
        expected_arms.push_back(predict_arm(p));
        poses_accepted++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: stall at random, compare each taken word with the oldest
  // prediction
  // ---------------------------------------------------------------------------
  initial begin : arm_checker
    arm_t want;
    int   n;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      // A requested long hold takes the place of one random stall
      if (long_hold_cycles > 0) begin
        n = long_hold_cycles;
        long_hold_cycles = 0;
      end else begin
        n = $urandom_range(stall_max, 0);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_arms.size() == 0) begin
        $error("result word arrived with no pose outstanding");
        mismatch_count++;
      end else begin
        want = expected_arms.pop_front();
        check_field("elbow_x", want.elbow_x, elbow_x_o);
        check_field("elbow_y", want.elbow_y, elbow_y_o);
        check_field("wrist_x", want.wrist_x, wrist_x_o);
        check_field("wrist_y", want.wrist_y, wrist_y_o);
        check_field("tip_x", want.tip_x, tip_x_o);
        check_field("tip_y", want.tip_y, tip_y_o);
        check_field("cos_first", want.cos_first, cos_first_o);
        check_field("sin_first", want.sin_first, sin_first_o);
        check_field("cos_second", want.cos_second, cos_second_o);
        check_field("sin_second", want.sin_second, sin_second_o);
        check_field("cos_third", want.cos_third, cos_third_o);
        check_field("sin_third", want.sin_third, sin_third_o);
        results_checked++;
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Quadrant boundaries, angle wrap and saturation at the reset lengths
  task automatic test_directed_poses();
    gap_max   = 2;
    stall_max = 2;
    send_pose(make_pose(0, 0, 0, 0, 0));
    send_pose(make_pose(0, 0, 16384, 0, 0));
    send_pose(make_pose(0, 0, -32768, 0, 0));
    send_pose(make_pose(0, 0, -16384, 0, 0));
    send_pose(make_pose(0, 0, 32767, 32767, 32767));
    send_pose(make_pose(0, 0, -32768, -32768, -32768));
    send_pose(make_pose(0, 0, 16384, 16384, 16384));
    send_pose(make_pose(0, 0, 8192, 8192, 8192));
    send_pose(make_pose(0, 0, 1, -1, 1));
    send_pose(make_pose(0, 0, 16383, 1, -16385));
    send_pose(make_pose(POS_MAX, POS_MAX, 0, 0, 0));
    send_pose(make_pose(POS_MIN, POS_MIN, -32768, 0, 0));
    send_pose(make_pose(POS_MAX, POS_MIN, 0, -16384, 0));
    send_pose(make_pose(POS_MIN, POS_MAX, 16384, 0, 16384));
    send_pose(make_pose(-1, -1, -1, -1, -1));
    send_pose(make_pose(4096, -4096, 12345, -23456, 30000));
  endtask

  // Zero and full-scale lengths, plus writes to the unused register index
  task automatic test_link_extremes();
    program_links('0, '0, '0, 1'b1);
    send_pose(make_pose(POS_MAX, POS_MIN, 16384, 8192, -8192));
    send_pose(make_pose(123456, -654321, 5000, 6000, 7000));
    program_links('1, '1, '1, 1'b1);
    send_pose(make_pose(POS_MAX, POS_MAX, 0, 0, 0));
    send_pose(make_pose(POS_MIN, POS_MIN, -32768, 0, 0));
    send_pose(make_pose(POS_MAX, POS_MIN, -16384, -16384, 0));
    send_pose(make_pose(0, 0, 16384, 0, 0));
    send_pose(make_pose(0, 0, -8192, -8192, -8192));
  endtask

  // Random poses across several link settings, with and without idling
  task automatic test_random_poses();
    logic [LEN_W-1:0] len [3];
    for (int round = 0; round < 6; round++) begin
      case (round)
        0:       len = '{LEN_ONE_RESET, LEN_TWO_RESET, LEN_THREE_RESET};
        1:       len = '{'1, '1, '1};
        2:       len = '{'0, '1, LEN_W'($urandom)};
        default: len = '{LEN_W'($urandom), LEN_W'($urandom), LEN_W'($urandom)};
      endcase
      program_links(len[0], len[1], len[2], round[0]);
      case (round % 3)
        0: begin
          gap_max   = 0;
          stall_max = 0;
        end
        1: begin
          gap_max   = 7;
          stall_max = 7;
        end
        default: begin
          gap_max   = 3;
          stall_max = 7;
        end
      endcase
      repeat (270) send_pose(random_pose());
    end
  endtask

  // Hold the output long enough for the pipeline and skid to fill up while
  // words keep arriving, so the block has to stall its input.
  task automatic test_output_backpressure();
    program_links(LEN_W'($urandom), LEN_W'($urandom), LEN_W'($urandom), 1'b0);
    gap_max          = 0;
    stall_max        = 0;
    long_hold_cycles = HOLD_CYCLES;
    repeat (80) send_pose(random_pose());
    stall_max = 7;
    gap_max   = 7;
    repeat (20) send_pose(random_pose());
  endtask

  initial begin : run_tests
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    poses_sent       = 0;
    poses_accepted   = 0;
    results_checked  = 0;
    mismatch_count   = 0;
    settings_count   = 0;
    cycle_count      = 0;
    gap_max          = 0;
    stall_max        = 0;
    long_hold_cycles = 0;
    link_len[REG_LINK_ONE]   = LEN_ONE_RESET;
    link_len[REG_LINK_TWO]   = LEN_TWO_RESET;
    link_len[REG_LINK_THREE] = LEN_THREE_RESET;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_poses();
    test_link_extremes();
    test_random_poses();
    test_output_backpressure();

    // Drain, then give any stray word time to show up
    wait_idle();
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("Checked %0d poses over %0d link settings in %0d cycles,", results_checked,
             settings_count, cycle_count);
    $display("including zero and full-scale links, stray index writes and a long hold.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
